>>> rtl/crcfbr_pkg.sv
// Shared types, constants and the byte-wise CRC-16 update of the framed byte receiver.
// Used by crcfbr_front, crcfbr_back and crc_framed_byte_receiver; depends on nothing.
package crcfbr_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] GEN_POLY   = 16'h1021;
  localparam logic [7:0]  SYNC_RESET = 8'hAA;

  typedef enum logic [2:0] {
    KIND_ID     = 3'd0,
    KIND_LEN    = 3'd1,
    KIND_DATA   = 3'd2,
    KIND_CRC_LO = 3'd3,
    KIND_CRC_HI = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] rx_byte;
  } mid_item_t;

  typedef struct packed {
    logic [7:0] frame_id;
    logic [7:0] data_byte;
    logic       has_data;
    logic       frame_end;
    logic       crc_good;
    logic [7:0] frame_length;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ GEN_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/crcfbr_fifo.sv
// Small synchronous queue of 2**DEPTH_LOG2 entries with push/full and pop/empty sides.
// Stand-alone; instantiated between front and back and on the result side.
module crcfbr_fifo #(
  parameter int WIDTH      = 11,
  parameter int DEPTH_LOG2 = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]    slot_r [DEPTH];
  logic [DEPTH_LOG2:0] wr_ptr_r;
  logic [DEPTH_LOG2:0] rd_ptr_r;
  logic                do_push;
  logic                do_pop;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[DEPTH_LOG2] != rd_ptr_r[DEPTH_LOG2]) &&
                   (wr_ptr_r[DEPTH_LOG2-1:0] == rd_ptr_r[DEPTH_LOG2-1:0]);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r[DEPTH_LOG2-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r[DEPTH_LOG2-1:0]] <= wdata;
    end
  end

endmodule

>>> rtl/crcfbr_front.sv
// Front end: holds the sync register, tracks the frame phase and tags every in-frame byte.
// Depends on crcfbr_pkg; feeds the queue ahead of crcfbr_back.
module crcfbr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_sync_byte,
  input  logic                  in_take,
  input  logic [7:0]            in_rx_byte,
  output logic                  mid_push,
  output crcfbr_pkg::mid_item_t mid_item
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_ID     = 3'd1,
    PH_LEN    = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRC_LO = 3'd4,
    PH_CRC_HI = 3'd5
  } phase_t;

  phase_t     phase_r;
  logic [7:0] sync_r;
  logic [7:0] len_r;
  logic [7:0] seen_r;
  logic [7:0] seen_inc;

  assign seen_inc = seen_r + 8'd1;

  always_comb begin
    mid_push         = in_take;
    mid_item.rx_byte = in_rx_byte;
    mid_item.kind    = crcfbr_pkg::KIND_ID;
    unique case (phase_r)
      PH_ID:     mid_item.kind = crcfbr_pkg::KIND_ID;
      PH_LEN:    mid_item.kind = crcfbr_pkg::KIND_LEN;
      PH_DATA:   mid_item.kind = crcfbr_pkg::KIND_DATA;
      PH_CRC_LO: mid_item.kind = crcfbr_pkg::KIND_CRC_LO;
      PH_CRC_HI: mid_item.kind = crcfbr_pkg::KIND_CRC_HI;
      default:   mid_push      = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sync_r  <= crcfbr_pkg::SYNC_RESET;
      len_r   <= '0;
      seen_r  <= '0;
    end else begin
      if (cfg_we) begin
        sync_r <= cfg_sync_byte;
      end
      if (in_take) begin
        unique case (phase_r)
          PH_ID: begin
            phase_r <= PH_LEN;
          end
          PH_LEN: begin
            len_r   <= in_rx_byte;
            seen_r  <= '0;
            phase_r <= (in_rx_byte == 8'd0) ? PH_CRC_LO : PH_DATA;
          end
          PH_DATA: begin
            seen_r <= seen_inc;
            if (seen_inc == len_r) begin
              phase_r <= PH_CRC_LO;
            end
          end
          PH_CRC_LO: begin
            phase_r <= PH_CRC_HI;
          end
          PH_CRC_HI: begin
            phase_r <= PH_HUNT;
          end
          default: begin
            phase_r <= (in_rx_byte == sync_r) ? PH_ID : PH_HUNT;
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/crcfbr_back.sv
// Back end: runs the CRC over the ID, length and data bytes and builds payload and frame-end results.
// Depends on crcfbr_pkg; drains the middle queue into the result queue.
module crcfbr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  mid_empty,
  input  crcfbr_pkg::mid_item_t mid_item,
  output logic                  mid_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output crcfbr_pkg::result_t   res_item
);

  logic [15:0] crc_r;
  logic [7:0]  id_r;
  logic [7:0]  len_r;
  logic [7:0]  crc_lo_r;
  logic [15:0] crc_base;
  logic [15:0] crc_upd;

  assign mid_pop  = !mid_empty && !res_full;
  assign crc_base = (mid_item.kind == crcfbr_pkg::KIND_ID) ? crcfbr_pkg::CRC_INIT : crc_r;
  assign crc_upd  = crcfbr_pkg::crc_feed(crc_base, mid_item.rx_byte);

  always_comb begin
    res_push              = 1'b0;
    res_item.frame_id     = id_r;
    res_item.data_byte    = 8'd0;
    res_item.has_data     = 1'b0;
    res_item.frame_end    = 1'b0;
    res_item.crc_good     = 1'b0;
    res_item.frame_length = len_r;
    unique case (mid_item.kind)
      crcfbr_pkg::KIND_DATA: begin
        res_push           = mid_pop;
        res_item.data_byte = mid_item.rx_byte;
        res_item.has_data  = 1'b1;
      end
      crcfbr_pkg::KIND_CRC_HI: begin
        res_push           = mid_pop;
        res_item.frame_end = 1'b1;
        res_item.crc_good  = ({mid_item.rx_byte, crc_lo_r} == crc_r);
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= crcfbr_pkg::CRC_INIT;
      id_r     <= '0;
      len_r    <= '0;
      crc_lo_r <= '0;
    end else if (mid_pop) begin
      unique case (mid_item.kind)
        crcfbr_pkg::KIND_ID: begin
          id_r  <= mid_item.rx_byte;
          crc_r <= crc_upd;
        end
        crcfbr_pkg::KIND_LEN: begin
          len_r <= mid_item.rx_byte;
          crc_r <= crc_upd;
        end
        crcfbr_pkg::KIND_DATA: begin
          crc_r <= crc_upd;
        end
        crcfbr_pkg::KIND_CRC_LO: begin
          crc_lo_r <= mid_item.rx_byte;
        end
        default: begin
          crc_r <= crc_r;
        end
      endcase
    end
  end

endmodule

>>> rtl/crc_framed_byte_receiver.sv
// Top level of the CRC-16 framed byte receiver: front end, middle queue, back end, result queue.
// Depends on crcfbr_pkg, crcfbr_fifo, crcfbr_front and crcfbr_back.
//
// channel  direction  handshake          payload
// in_      in         in_push / in_full  in_rx_byte
// out_     out        out_pop / out_empty frame_id, data_byte, has_data, frame_end,
//                                        crc_good, frame_length
// cfg_     in         cfg_valid/cfg_ready cfg_sync_byte
//
// One byte per cycle while in_full is low; a result passes through the middle queue and then
// the result queue, both registered, before it is poppable.
// Reset (rst_n low, synchronous): both queues empty, hunting, sync byte 0xAA.
// A full result queue stalls the back end; a full middle queue raises in_full.
// cfg_ready is always high.
module crc_framed_byte_receiver #(
  parameter int MID_DEPTH_LOG2 = 1,
  parameter int OUT_DEPTH_LOG2 = 1
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_rx_byte,
  output logic       in_full,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_frame_id,
  output logic [7:0] out_data_byte,
  output logic       out_has_data,
  output logic       out_frame_end,
  output logic       out_crc_good,
  output logic [7:0] out_frame_length,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_sync_byte
);

  localparam int MID_W = $bits(crcfbr_pkg::mid_item_t);
  localparam int RES_W = $bits(crcfbr_pkg::result_t);

  logic                  in_take;
  logic                  mid_push;
  logic                  mid_full;
  logic                  mid_empty;
  logic                  mid_pop;
  crcfbr_pkg::mid_item_t mid_wr;
  crcfbr_pkg::mid_item_t mid_rd;
  logic                  res_push;
  logic                  res_full;
  crcfbr_pkg::result_t   res_wr;
  crcfbr_pkg::result_t   res_rd;

  assign cfg_ready = 1'b1;
  assign in_full   = mid_full;
  assign in_take   = in_push && !mid_full;

  crcfbr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_sync_byte (cfg_sync_byte),
    .in_take       (in_take),
    .in_rx_byte    (in_rx_byte),
    .mid_push      (mid_push),
    .mid_item      (mid_wr)
  );

  crcfbr_fifo #(
    .WIDTH      (MID_W),
    .DEPTH_LOG2 (MID_DEPTH_LOG2)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wr),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rd),
    .empty (mid_empty)
  );

  crcfbr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_item  (mid_rd),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_wr)
  );

  crcfbr_fifo #(
    .WIDTH      (RES_W),
    .DEPTH_LOG2 (OUT_DEPTH_LOG2)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wr),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rd),
    .empty (out_empty)
  );

  assign out_frame_id     = res_rd.frame_id;
  assign out_data_byte    = res_rd.data_byte;
  assign out_has_data     = res_rd.has_data;
  assign out_frame_end    = res_rd.frame_end;
  assign out_crc_good     = res_rd.crc_good;
  assign out_frame_length = res_rd.frame_length;

endmodule
